// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent assertions of the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define SCF_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scf assertion failed");

// Property checked at every clock edge, reset included.
`define SCF_ASSERT_RST(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("scf assertion failed during reset");

`endif

// ----- hw/rtl/scf_pkg.sv -----
// ----------------------------------------------------------------------------
// scf_pkg
// Types, constants and helper functions of the substring search block.
// ----------------------------------------------------------------------------
package scf_pkg;

  // Default sizes handed to the top level parameters.
  localparam int unsigned PATTERN_MAX_DEF = 16;
  localparam int unsigned TEXT_MAX_DEF    = 65536;

  // Fixed field and register widths.
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PAT_BYTES   = 16;
  localparam int unsigned PLEN_W      = 5;
  localparam int unsigned LIMIT_W     = 17;
  localparam int unsigned POS_W       = 16;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned SPAN_MAX    = 65536;

  // ASCII case folding constants.
  localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [BYTE_W-1:0] FOLD_OFFSET  = 8'd32;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CASE_FOLD    = 3'd0,
    REG_PATTERN_LEN  = 3'd1,
    REG_PATTERN_LOW  = 3'd2,
    REG_PATTERN_HIGH = 3'd3,
    REG_SEARCH_LIMIT = 3'd4
  } cfg_reg_e;

  // Input beat payload.
  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              last;
  } in_t;

  // Result beat payload.
  typedef struct packed {
    logic             decided;
    logic             found;
    logic [POS_W-1:0] match_position;
  } out_t;

  // Configuration register contents shared between modules.
  typedef struct packed {
    logic                           case_fold;
    logic [PLEN_W-1:0]              pattern_length;
    logic [PAT_BYTES-1:0][BYTE_W-1:0] pattern;
    logic [LIMIT_W-1:0]             search_limit;
  } cfg_t;

  // Folds an upper-case ASCII letter to lower case when enabled.
  function automatic logic [BYTE_W-1:0] fold_byte(input logic [BYTE_W-1:0] b,
                                                  input logic en);
    logic [BYTE_W-1:0] r;
    r = b;
    if (en && (b >= CHAR_UPPER_A) && (b <= CHAR_UPPER_Z)) begin
      r = b + FOLD_OFFSET;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/scf_cfg.sv -----
// ----------------------------------------------------------------------------
// scf_cfg
// Configuration register file of the substring search block.
// ----------------------------------------------------------------------------
module scf_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [scf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [scf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output scf_pkg::cfg_t                cfg_o
);
  import scf_pkg::*;

  cfg_t cfg_q;

  // Writes are taken in every cycle.
  assign cfg_ready_o = 1'b1;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.case_fold      <= 1'b0;
      cfg_q.pattern_length <= '0;
      cfg_q.pattern        <= '0;
      cfg_q.search_limit   <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CASE_FOLD:    cfg_q.case_fold      <= cfg_data_i[0];
        REG_PATTERN_LEN:  cfg_q.pattern_length <= cfg_data_i[PLEN_W-1:0];
        REG_PATTERN_LOW:  cfg_q.pattern[7:0]   <= cfg_data_i;
        REG_PATTERN_HIGH: cfg_q.pattern[15:8]  <= cfg_data_i;
        REG_SEARCH_LIMIT: cfg_q.search_limit   <= cfg_data_i[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/scf_match.sv -----
// ----------------------------------------------------------------------------
// scf_match
// Window against pattern compare with optional ASCII case folding.
// ----------------------------------------------------------------------------
module scf_match #(
  parameter int unsigned WIN_D = scf_pkg::PATTERN_MAX_DEF,
  localparam int unsigned LEN_W = $clog2(WIN_D + 1)
) (
  input  scf_pkg::cfg_t                         cfg_i,
  input  logic [WIN_D-1:0][scf_pkg::BYTE_W-1:0] window_i,
  output logic [LEN_W-1:0]                      len_o,
  output logic                                  match_o
);
  import scf_pkg::*;

  logic [LEN_W-1:0]  len;
  logic [WIN_D-1:0]  hit;

  // Pattern lengths above the window depth saturate.
  always_comb begin
    if (32'(cfg_i.pattern_length) > WIN_D) begin
      len = LEN_W'(WIN_D);
    end else begin
      len = LEN_W'(cfg_i.pattern_length);
    end
  end

  // Window byte j (newest at 0) lines up with pattern byte len-1-j.
  always_comb begin
    logic [PLEN_W-1:0] idx;
    for (int j = 0; j < WIN_D; j++) begin
      idx    = PLEN_W'(len) - PLEN_W'(j) - PLEN_W'(1);
      hit[j] = (PLEN_W'(j) >= PLEN_W'(len)) ||
               (fold_byte(window_i[j], cfg_i.case_fold) ==
                fold_byte(cfg_i.pattern[idx[3:0]], cfg_i.case_fold));
    end
  end

  assign len_o   = len;
  assign match_o = &hit;

endmodule

// ----- hw/rtl/substring_find_case_fold_unit.sv -----
// ----------------------------------------------------------------------------
// substring_find_case_fold_unit
// Streaming first-occurrence substring search with optional case folding.
// ----------------------------------------------------------------------------
// Usage: text bytes arrive one per input beat, with last on the final byte.
// Every input beat yields exactly one result beat carrying decided, found
// and match_position. A beat is accepted when valid and ready are high.
// An accepted byte goes to the input register, whose byte feeds the window
// compare straight into the result register. Throughput is one byte per
// cycle while the receiver does not stall, set by the window compare and the
// state update that sits beside it.
// When the receiver stalls, the result register holds; the input register
// still takes one more beat, and ready drops only when both are full.
// Configuration is written through its own channel, always ready; the user
// must write it only while no item is in flight, the block does not enforce it.
// Reset clears the window, byte count, settled flag and the valid flags of
// both pipeline registers; configuration gets its defaults (search limit unlimited).
// ----------------------------------------------------------------------------
module substring_find_case_fold_unit #(
  parameter int unsigned PATTERN_MAX = scf_pkg::PATTERN_MAX_DEF,
  parameter int unsigned TEXT_MAX    = scf_pkg::TEXT_MAX_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  scf_pkg::in_t                   in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output scf_pkg::out_t                  out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [scf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [scf_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import scf_pkg::*;

  localparam int unsigned WIN_D = PATTERN_MAX;
  localparam int unsigned LEN_W = $clog2(WIN_D + 1);
  localparam int unsigned SPAN  = (TEXT_MAX < SPAN_MAX) ? TEXT_MAX : SPAN_MAX;
  localparam int unsigned CNT_W = $clog2(SPAN + 1);

  cfg_t cfg;

  logic                          in_valid_q;
  in_t                           in_q;
  logic                          out_valid_q;
  out_t                          out_q;
  out_t                          out_d;
  logic [WIN_D-1:0][BYTE_W-1:0]  win_q;
  logic [WIN_D-1:0][BYTE_W-1:0]  win_new;
  logic [CNT_W-1:0]              cnt_q;
  logic                          settled_q;
  logic                          advance;

  logic [LEN_W-1:0]   len;
  logic               pat_match;
  logic [LIMIT_W-1:0] cur;
  logic [LIMIT_W-1:0] nxt;
  logic [LIMIT_W-1:0] lim;
  logic [LIMIT_W-1:0] len_ext;
  logic               limited;
  logic               match;
  logic               ending;

  scf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Handshake: the held byte moves on when the result register is free.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  // Window with the held byte shifted in at the newest end.
  always_comb begin
    win_new[0] = in_q.text_byte;
    for (int k = 1; k < WIN_D; k++) begin
      win_new[k] = win_q[k-1];
    end
  end

  scf_match #(
    .WIN_D (WIN_D)
  ) u_match (
    .cfg_i    (cfg),
    .window_i (win_new),
    .len_o    (len),
    .match_o  (pat_match)
  );

  // Decision for the held byte from count, limit and compare result.
  assign cur     = LIMIT_W'(cnt_q);
  assign nxt     = cur + LIMIT_W'(1);
  assign limited = !cfg.search_limit[LIMIT_W-1];
  assign lim     = {1'b0, cfg.search_limit[LIMIT_W-2:0]};
  assign len_ext = LIMIT_W'(len);
  assign match   = (len == '0) ||
                   ((nxt >= len_ext) && (!limited || (cur < lim)) && pat_match);
  assign ending  = (limited && (nxt >= lim)) || in_q.last ||
                   (nxt >= LIMIT_W'(SPAN));

  always_comb begin
    out_d = '0;
    if (!settled_q) begin
      if (match) begin
        out_d.decided = 1'b1;
        out_d.found   = 1'b1;
        if (len != '0) begin
          out_d.match_position = POS_W'(nxt - len_ext);
        end
      end else if (ending) begin
        out_d.decided = 1'b1;
      end
    end
  end

  // Per-text state: window, byte count and settled flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= '0;
      cnt_q     <= '0;
      settled_q <= 1'b0;
    end else if (advance) begin
      if (in_q.last) begin
        win_q     <= '0;
        cnt_q     <= '0;
        settled_q <= 1'b0;
      end else if (!settled_q) begin
        win_q     <= win_new;
        cnt_q     <= nxt[CNT_W-1:0];
        settled_q <= out_d.decided;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hw/rtl/scf_checker.sv -----
// ----------------------------------------------------------------------------
// scf_checker
// Port-level checks of the substring search block, bound to its top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module scf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input scf_pkg::out_t                  out_data_o
);
  import scf_pkg::*;

  // No result beat is offered while in reset.
  `SCF_ASSERT_RST(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_o)

  // A stalled result beat keeps its payload.
  `SCF_ASSERT(a_result_held, clk_i, rst_ni,
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))

  // A match is only reported on the beat that settles the answer.
  `SCF_ASSERT(a_found_decided, clk_i, rst_ni,
    out_valid_o && out_data_o.found |-> out_data_o.decided)

  // The position reads zero when nothing was found.
  `SCF_ASSERT(a_pos_zero, clk_i, rst_ni,
    out_valid_o && !out_data_o.found |-> out_data_o.match_position == '0)

  // With the result side empty the block always takes a new beat.
  `SCF_ASSERT(a_ready_when_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o)

endmodule

bind substring_find_case_fold_unit scf_checker u_scf_checker (.*);

// ----- sim/substring_find_case_fold_unit_tb.sv -----
// ----------------------------------------------------------------------------
// substring_find_case_fold_unit_tb
// Self-checking bench for the streaming substring search block.
// ----------------------------------------------------------------------------
// Text bytes are driven through the input channel. A scoreboard keeps its own
// copy of the window, byte count and settled flag, works out the answer
// for every accepted byte, and compares each result beat with it in order.
// A short directed part comes first. Randomized phases follow,
// each with fresh register values and one of four mixes of gaps and stalls.
// ----------------------------------------------------------------------------
module substring_find_case_fold_unit_tb;
  import scf_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 10;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned PHASE_COUNT    = 8;
  localparam int unsigned PHASE_BYTES    = 230;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned WINDOW_DEPTH   = (PATTERN_MAX_DEF < 16) ? PATTERN_MAX_DEF : 16;
  localparam int unsigned SEARCH_SPAN    = (TEXT_MAX_DEF < SPAN_MAX) ? TEXT_MAX_DEF : SPAN_MAX;
  localparam logic [LIMIT_W-1:0] NO_LIMIT = '1;

  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // Predicts the answer for every accepted text byte and checks result beats.
  class match_checker;
    bit                          case_fold;
    bit [PLEN_W-1:0]             pattern_len;
    bit [PAT_BYTES-1:0][BYTE_W-1:0] pattern;
    bit [LIMIT_W-1:0]            search_limit;
    bit [15:0][BYTE_W-1:0]       window;
    bit [LIMIT_W-1:0]            byte_count;
    bit                          settled;
    out_t                        answer_q[$];
    int unsigned                 errors;

    function new();
      case_fold    = 1'b0;
      pattern_len  = '0;
      pattern      = '0;
      search_limit = NO_LIMIT;
      errors       = 0;
      clear_text();
    endfunction

    function void clear_text();
      window     = '0;
      byte_count = '0;
      settled    = 1'b0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_CASE_FOLD:    case_fold = data[0];
        REG_PATTERN_LEN:  pattern_len = data[PLEN_W-1:0];
        REG_PATTERN_LOW:  pattern[7:0] = data;
        REG_PATTERN_HIGH: pattern[15:8] = data;
        REG_SEARCH_LIMIT: search_limit = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    // Pattern length as the compare uses it, saturated to the window depth.
    function int unsigned active_len();
      return (pattern_len > WINDOW_DEPTH) ? WINDOW_DEPTH : pattern_len;
    endfunction

    function logic [BYTE_W-1:0] fold_letter(logic [BYTE_W-1:0] b);
      if (case_fold && b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) return b + FOLD_OFFSET;
      return b;
    endfunction

    // Notes an accepted byte and queues the answer that it must produce.
    function void take_byte(in_t beat);
      out_t        res;
      int unsigned len, cnt, lim;
      bit          limited, hit;
      res = '0;
      if (!settled) begin
        cnt     = 32'(byte_count);
        len     = active_len();
        limited = !search_limit[LIMIT_W-1];
        lim     = 32'(search_limit[LIMIT_W-2:0]);
        window  = {window[14:0], beat.text_byte};
        hit     = 1'b0;
        if (len == 0) begin
          hit = 1'b1;
        end else if (cnt + 1 >= len && (!limited || cnt < lim)) begin
          hit = 1'b1;
          for (int i = 0; i < len; i++) begin
            if (fold_letter(window[len-1-i]) != fold_letter(pattern[i])) hit = 1'b0;
          end
        end
        if (hit) begin
          res.decided        = 1'b1;
          res.found          = 1'b1;
          res.match_position = (len == 0) ? '0 : POS_W'(cnt + 1 - len);
          settled            = 1'b1;
        end else if ((limited && cnt + 1 >= lim) || beat.last || cnt + 1 >= SEARCH_SPAN) begin
          res.decided = 1'b1;
          settled     = 1'b1;
        end
        byte_count = byte_count + 1'b1;
      end
      if (beat.last) clear_text();
      answer_q.push_back(res);
    endfunction

    // Compares a result beat with the oldest queued answer.
    function void check_answer(out_t got);
      out_t want;
      if (answer_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result beat: decided=%0b found=%0b position=%0d",
                   got.decided, got.found, got.match_position);
        return;
      end
      want = answer_q.pop_front();
      if (got.decided !== want.decided || got.found !== want.found ||
          got.match_position !== want.match_position) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch: expected decided=%0b found=%0b position=%0d, %s%0b %s%0b %s%0d",
                   want.decided, want.found, want.match_position,
                   "got decided=", got.decided, "found=", got.found,
                   "position=", got.match_position);
      end
    endfunction

    function int unsigned pending();
      return answer_q.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_t                   in_data_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_t                  out_data_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  match_checker  sb;
  idle_mode_e    idle_mode;
  int unsigned   quiet_cycles;
  int unsigned   phase_bytes;

  substring_find_case_fold_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Receiver stalls, drawn anew at every falling edge.
  always @(negedge clk_i) begin
    case (idle_mode)
      IDLE_RECEIVER: out_ready_i <= ($urandom_range(99) >= 71);
      IDLE_BOTH:     out_ready_i <= ($urandom_range(99) >= 17);
      default:       out_ready_i <= 1'b1;
    endcase
  end

  // Every accepted result beat goes to the scoreboard.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_answer(out_data_o);
  end

  // Watchdog: ends the run after a long stretch with no beat on any channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic bit sender_gap();
    if (idle_mode == IDLE_SENDER) return $urandom_range(99) < 71;
    if (idle_mode == IDLE_BOTH) return $urandom_range(99) < 17;
    return 1'b0;
  endfunction

  // Drives one text byte; valid stays high on return so beats run back to back.
  task automatic send_beat(input logic [BYTE_W-1:0] b, input logic last);
    in_t beat;
    beat.text_byte = b;
    beat.last      = last;
    while (sender_gap()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.take_byte(beat);
    @(negedge clk_i);
  endtask

  task automatic send_bytes(input logic [BYTE_W-1:0] bytes_q[$]);
    foreach (bytes_q[i]) send_beat(bytes_q[i], i == bytes_q.size() - 1);
  endtask

  // Drops valid and waits until every queued answer has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Writes all five registers; with junk set, unused upper data bits are random.
  task automatic set_config(input bit fold, input logic [PLEN_W-1:0] len,
                            input logic [CFG_DATA_W-1:0] lo, input logic [CFG_DATA_W-1:0] hi,
                            input logic [LIMIT_W-1:0] lim, input bit junk);
    logic [CFG_DATA_W-1:0] data [5];
    cfg_reg_e              idx  [5];
    logic [CFG_DATA_W-1:0] noise;
    noise = junk ? {$urandom, $urandom} : '0;
    idx[0] = REG_CASE_FOLD;    data[0] = {noise[63:1], fold};
    idx[1] = REG_PATTERN_LEN;  data[1] = {noise[63:PLEN_W], len};
    idx[2] = REG_PATTERN_LOW;  data[2] = lo;
    idx[3] = REG_PATTERN_HIGH; data[3] = hi;
    idx[4] = REG_SEARCH_LIMIT; data[4] = {noise[63:LIMIT_W], lim};
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= data[i];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      sb.write_reg(idx[i], data[i]);
      @(negedge clk_i);
    end
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Flips the case of a letter now and then, mostly when folding is on.
  function automatic logic [BYTE_W-1:0] vary_case(input logic [BYTE_W-1:0] b);
    bit letter;
    letter = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
    if (letter && $urandom_range(sb.case_fold ? 1 : 9) == 0) return b ^ 8'h20;
    return b;
  endfunction

  // Text filler close to the pattern so that partial matches are common.
  function automatic logic [BYTE_W-1:0] filler_byte();
    case ($urandom_range(9))
      0, 1:    return BYTE_W'($urandom);
      2, 3:    return vary_case("a" + BYTE_W'($urandom_range(2)));
      default: return vary_case(sb.pattern[$urandom_range(sb.active_len() > 0 ?
                                                          sb.active_len() - 1 : 0)]);
    endcase
  endfunction

  // Sends one random text, usually with a copy of the pattern inside it.
  task automatic send_text(input bit noisy);
    int unsigned         len, plen, at;
    logic [BYTE_W-1:0]   text_q[$];
    len  = ($urandom_range(7) == 0) ? $urandom_range(60, 1) : $urandom_range(24, 1);
    plen = sb.active_len();
    for (int i = 0; i < len; i++) text_q.push_back(noisy ? BYTE_W'($urandom) : filler_byte());
    if (!noisy && plen != 0 && plen <= len && $urandom_range(3) != 0) begin
      at = $urandom_range(len - plen);
      for (int i = 0; i < plen; i++) text_q[at+i] = vary_case(sb.pattern[i]);
      // A broken copy now and then.
      if ($urandom_range(7) == 0)
        text_q[at + $urandom_range(plen - 1)] ^= BYTE_W'(1 << $urandom_range(7));
    end
    send_bytes(text_q);
    phase_bytes += len;
  endtask

  // Random register values with the extremes mixed in.
  task automatic random_config(input bit junk);
    logic [PAT_BYTES-1:0][BYTE_W-1:0] pat;
    logic [PLEN_W-1:0]                len;
    logic [LIMIT_W-1:0]               lim;
    case ($urandom_range(9))
      0:       len = '0;
      1:       len = PLEN_W'(16);
      2:       len = PLEN_W'($urandom_range(31, 17));
      default: len = PLEN_W'($urandom_range(6, 1));
    endcase
    for (int i = 0; i < PAT_BYTES; i++) begin
      case ($urandom_range(7))
        0:       pat[i] = 8'h00;
        1:       pat[i] = 8'hFF;
        2:       pat[i] = BYTE_W'($urandom);
        default: pat[i] = ($urandom_range(1) ? "A" : "a") + BYTE_W'($urandom_range(2));
      endcase
    end
    case ($urandom_range(5))
      0:       lim = '0;
      1:       lim = LIMIT_W'($urandom_range(40, 1));
      2:       lim = {1'b1, 16'($urandom)};
      default: lim = NO_LIMIT;
    endcase
    set_config(1'($urandom_range(1)), len, pat[7:0], pat[15:8], lim, junk);
  endtask

  initial begin
    logic [BYTE_W-1:0] seq[$];
    logic [PAT_BYTES-1:0][BYTE_W-1:0] pat;

    sb           = new();
    idle_mode    = IDLE_NONE;
    quiet_cycles = 0;
    phase_bytes  = 0;
    clk_i        = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_ready_i  = 1'b0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = REG_CASE_FOLD;
    cfg_data_i   = '0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset registers: empty pattern matches at once; zero bytes are plain data.
    seq = '{8'h00, 8'hFF, 8'h80};
    send_bytes(seq);
    wait_idle();

    // Empty pattern still matches when the limit is zero.
    set_config(1'b0, '0, '0, '0, '0, 1'b0);
    seq = '{8'h41};
    send_bytes(seq);
    wait_idle();

    // Folded match under a negative limit, which means no limit.
    set_config(1'b1, PLEN_W'(3), 64'h7A_42_61, '0, 17'h10003, 1'b0);
    seq = '{"x", "A", "b", "Z"};
    send_bytes(seq);
    wait_idle();

    // Limit of zero with a real pattern settles on the first byte.
    set_config(1'b1, PLEN_W'(3), 64'h7A_42_61, '0, '0, 1'b0);
    seq = '{"a"};
    send_bytes(seq);
    wait_idle();

    // Over-long length saturates; the full-width match ends right at the limit.
    // Characters next to the letter ranges must not fold.
    pat[7:0]  = 64'h00FF_807A_5A41_6100;
    pat[15:8] = 64'h5B40_7B60_4D6D_0102;
    set_config(1'b1, PLEN_W'(20), pat[7:0], pat[15:8], LIMIT_W'(16), 1'b0);
    seq = {};
    for (int i = 0; i < PAT_BYTES; i++) begin
      seq.push_back(((pat[i] >= "A" && pat[i] <= "Z") || (pat[i] >= "a" && pat[i] <= "z"))
                    ? pat[i] ^ 8'h20 : pat[i]);
    end
    send_bytes(seq);
    wait_idle();

    // No folding: a case-swapped text ends without a match.
    set_config(1'b0, PLEN_W'(2), 64'h62_61, '0, NO_LIMIT, 1'b0);
    seq = '{"A", "B"};
    send_bytes(seq);
    wait_idle();

    // Largest limit: a match well inside it is still found.
    set_config(1'b1, PLEN_W'(4), 64'h7A79_7877, '0, LIMIT_W'(65535), 1'b0);
    seq = '{"a", "W", "x", "Y", "z", 8'h00};
    send_bytes(seq);
    wait_idle();

    // Random phases, each with its own registers and idling mix.
    for (int p = 0; p < PHASE_COUNT; p++) begin
      random_config(p >= 2);
      idle_mode   = idle_mode_e'(p % 4);
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) send_text($urandom_range(4) == 0);
      wait_idle();
    end

    repeat (8) @(negedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
